/* hdl/bba_pkg.sv */
// Shared constants, command codes and controller/datapath bundles for the
// bitmap block allocator. No dependencies.
package bba_pkg;

  localparam int MAX_BLOCKS = 1024;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int MAP_BYTES  = (MAX_BLOCKS + 7) / 8;
  localparam int BYTE_AW    = $clog2(MAP_BYTES);
  localparam int CNT_W      = 11;
  localparam int POS_W      = 13;

  localparam logic [CNT_W-1:0] TOTAL_RESET = CNT_W'(1024);
  localparam logic [CNT_W-1:0] ALIGN_RESET = CNT_W'(1);

  localparam logic [1:0] CFG_TOTAL = 2'd0;
  localparam logic [1:0] CFG_ALIGN = 2'd1;

  typedef enum logic [1:0] {
    CMD_FWD = 2'd0,
    CMD_BACK = 2'd1,
    CMD_REL = 2'd2,
    CMD_QRY = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLR,
    OP_POS_ZERO,
    OP_POS_S,
    OP_POS_INC,
    OP_POS_DEC,
    OP_IDX_RUN,
    OP_IDX_INC,
    OP_IDX_S,
    OP_MARK,
    OP_Q_STEP,
    OP_RES_FAIL,
    OP_RES_RUN,
    OP_RES_QRY
  } op_e;

  typedef struct packed {
    cmd_e cmd;
    logic bounds_ok;
    logic align_more;
    logic cand_out;
    logic pos_past;
    logic bit_used;
    logic idx_last;
    logic q_empty;
    logic q_last;
    logic clr_last;
  } dp_status_t;

endpackage

/* hdl/bba_if.sv */
// Valid/ready channel interfaces for requests, responses and register writes.
// Depends on bba_pkg.
interface bba_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   cmd;
  logic [bba_pkg::CNT_W-1:0]    block_count;
  logic [bba_pkg::IDX_W-1:0]    start_block;
  logic [bba_pkg::CNT_W-1:0]    window_len;
  modport source (output valid, cmd, block_count, start_block, window_len, input ready);
  modport sink (input valid, cmd, block_count, start_block, window_len, output ready);
endinterface

interface bba_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         success;
  logic [bba_pkg::IDX_W-1:0]    run_base;
  logic [bba_pkg::CNT_W-1:0]    run_length;
  logic [bba_pkg::CNT_W-1:0]    largest_free;
  modport source (output valid, success, run_base, run_length, largest_free, input ready);
  modport sink (input valid, success, run_base, run_length, largest_free, output ready);
endinterface

interface bba_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   index;
  logic [bba_pkg::CNT_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/bba_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

/* hdl/bba_dp.sv */
// Datapath: config registers, request registers, search pointers, bitmap RAM
// and result registers. Depends on bba_pkg and bba_ram.
module bba_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bba_pkg::op_e              op_i,
  input  logic [1:0]                req_cmd_i,
  input  logic [bba_pkg::CNT_W-1:0] req_count_i,
  input  logic [bba_pkg::IDX_W-1:0] req_start_i,
  input  logic [bba_pkg::CNT_W-1:0] req_window_i,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [bba_pkg::CNT_W-1:0] cfg_data_i,
  output bba_pkg::dp_status_t       status_o,
  output logic                      res_ok_o,
  output logic [bba_pkg::IDX_W-1:0] res_base_o,
  output logic [bba_pkg::CNT_W-1:0] res_len_o,
  output logic [bba_pkg::CNT_W-1:0] res_large_o
);
  localparam int CW = bba_pkg::CNT_W;
  localparam int PW = bba_pkg::POS_W;
  localparam int IW = bba_pkg::IDX_W;

  logic [CW-1:0] total_q, align_q;
  bba_pkg::cmd_e cmd_q;
  logic [CW-1:0] cnt_q, w_q, cur_q, large_q;
  logic [IW-1:0] s_q;
  logic signed [PW-1:0] pos_q;
  logic [IW-1:0] idx_q;
  logic [7:0]    rdata;
  logic [7:0]    wdata;
  logic [7:0]    mask;
  logic          ram_we;

  logic [CW-1:0] n, a;
  logic signed [PW-1:0] sp, cp, wp, np, ap, ip, hi, lo, t_hi, t_lo;
  logic signed [PW-1:0] run_start, run_last;
  logic signed [PW-1:0] qend;
  logic is_back;

  always_comb begin
    n  = (total_q > CW'(bba_pkg::MAX_BLOCKS)) ? CW'(bba_pkg::MAX_BLOCKS) : total_q;
    a  = (align_q == '0) ? CW'(1) : align_q;
    sp = PW'(s_q);
    cp = PW'(cnt_q);
    wp = PW'(w_q);
    np = PW'(n);
    ap = PW'(a);
    ip = PW'(idx_q);
    is_back = (cmd_q == bba_pkg::CMD_BACK);
    t_hi = sp + wp - cp;
    hi   = (t_hi > np - cp) ? np - cp : t_hi;
    t_lo = sp + cp - wp;
    lo   = (t_lo < cp - PW'(1)) ? cp - PW'(1) : t_lo;
    run_start = is_back ? pos_q + PW'(1) - cp : pos_q;
    run_last  = is_back ? pos_q : pos_q + cp - PW'(1);
    qend      = (sp + wp >= np) ? np : sp + wp;
  end

  always_comb begin
    status_o.cmd = cmd_q;
    unique case (cmd_q)
      bba_pkg::CMD_FWD:
        status_o.bounds_ok = (cnt_q != '0) && (w_q >= cnt_q) && (sp + cp <= np);
      bba_pkg::CMD_BACK:
        status_o.bounds_ok = (cnt_q != '0) && (w_q >= cnt_q) && (sp < np) &&
                             (cp <= sp + PW'(1));
      default:
        status_o.bounds_ok = (cnt_q != '0) && (sp + cp <= np);
    endcase
    status_o.align_more = is_back ? (pos_q + ap <= sp) : (pos_q < sp);
    status_o.cand_out   = is_back ? (pos_q < lo) : (pos_q > hi);
    status_o.pos_past   = is_back ? (pos_q < ip) : (pos_q > ip);
    status_o.bit_used   = rdata[3'd7 - idx_q[2:0]];
    status_o.idx_last   = (ip == run_last);
    status_o.q_empty    = (sp >= np) || (w_q == '0);
    status_o.q_last     = (ip + PW'(1) == qend);
    status_o.clr_last   = &idx_q[IW-1:3];
  end

  // Byte-wide read-modify-write on the bitmap.
  always_comb begin
    mask   = 8'h80 >> idx_q[2:0];
    ram_we = (op_i == bba_pkg::OP_CLR) || (op_i == bba_pkg::OP_MARK);
    if (op_i == bba_pkg::OP_CLR) begin
      wdata = 8'h00;
    end else if (cmd_q == bba_pkg::CMD_REL) begin
      wdata = rdata & ~mask;
    end else begin
      wdata = rdata | mask;
    end
  end

  bba_ram #(.WIDTH(8), .DEPTH(bba_pkg::MAP_BYTES)) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (idx_q[IW-1:3]),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= bba_pkg::TOTAL_RESET;
      align_q <= bba_pkg::ALIGN_RESET;
      idx_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == bba_pkg::CFG_TOTAL) begin
          total_q <= cfg_data_i;
        end else if (cfg_index_i == bba_pkg::CFG_ALIGN) begin
          align_q <= cfg_data_i;
        end
      end
      case (op_i)
        bba_pkg::OP_CLR:     idx_q <= idx_q + IW'(8);
        bba_pkg::OP_IDX_RUN: idx_q <= run_start[IW-1:0];
        bba_pkg::OP_IDX_S:   idx_q <= s_q;
        bba_pkg::OP_IDX_INC, bba_pkg::OP_MARK, bba_pkg::OP_Q_STEP: idx_q <= idx_q + IW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      bba_pkg::OP_LOAD: begin
        cmd_q   <= bba_pkg::cmd_e'(req_cmd_i);
        cnt_q   <= req_count_i;
        s_q     <= req_start_i;
        w_q     <= req_window_i;
        cur_q   <= '0;
        large_q <= '0;
      end
      bba_pkg::OP_POS_ZERO: pos_q <= '0;
      bba_pkg::OP_POS_S:    pos_q <= sp;
      bba_pkg::OP_POS_INC:  pos_q <= pos_q + ap;
      bba_pkg::OP_POS_DEC:  pos_q <= pos_q - ap;
      bba_pkg::OP_Q_STEP: begin
        if (status_o.bit_used) begin
          cur_q <= '0;
        end else begin
          cur_q <= cur_q + CW'(1);
          if (cur_q + CW'(1) > large_q) begin
            large_q <= cur_q + CW'(1);
          end
        end
      end
      bba_pkg::OP_RES_FAIL: begin
        res_ok_o    <= 1'b0;
        res_base_o  <= '0;
        res_len_o   <= '0;
        res_large_o <= '0;
      end
      bba_pkg::OP_RES_RUN: begin
        res_ok_o    <= 1'b1;
        res_base_o  <= run_start[IW-1:0];
        res_len_o   <= cnt_q;
        res_large_o <= '0;
      end
      bba_pkg::OP_RES_QRY: begin
        res_ok_o    <= 1'b1;
        res_base_o  <= '0;
        res_len_o   <= '0;
        res_large_o <= large_q;
      end
      default: ;
    endcase
  end
endmodule

/* hdl/bba_ctrl.sv */
// Controller state machine: sequences clear, search, mark and query steps.
// Depends on bba_pkg.
module bba_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  input  bba_pkg::dp_status_t status_i,
  output bba_pkg::op_e        op_o
);
  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_CHECK, S_ALIGN, S_CAND, S_FETCH, S_TEST, S_ADV,
    S_MSTART, S_MFETCH, S_MWRITE, S_MRES, S_QFETCH, S_QTEST, S_QRES, S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    op_o    = bba_pkg::OP_NONE;
    unique case (state_q)
      S_CLR: begin
        op_o = bba_pkg::OP_CLR;
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid_i && req_ready_o) begin
          op_o    = bba_pkg::OP_LOAD;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.cmd == bba_pkg::CMD_QRY) begin
          if (status_i.q_empty) begin
            op_o    = bba_pkg::OP_RES_QRY;
            state_d = S_DONE;
          end else begin
            op_o    = bba_pkg::OP_IDX_S;
            state_d = S_QFETCH;
          end
        end else if (!status_i.bounds_ok) begin
          op_o    = bba_pkg::OP_RES_FAIL;
          state_d = S_DONE;
        end else if (status_i.cmd == bba_pkg::CMD_REL) begin
          op_o    = bba_pkg::OP_POS_S;
          state_d = S_MSTART;
        end else begin
          op_o    = bba_pkg::OP_POS_ZERO;
          state_d = S_ALIGN;
        end
      end
      S_ALIGN: begin
        if (status_i.align_more) op_o = bba_pkg::OP_POS_INC;
        else state_d = S_CAND;
      end
      S_CAND: begin
        if (status_i.cand_out) begin
          op_o    = bba_pkg::OP_RES_FAIL;
          state_d = S_DONE;
        end else begin
          op_o    = bba_pkg::OP_IDX_RUN;
          state_d = S_FETCH;
        end
      end
      S_FETCH: state_d = S_TEST;
      S_TEST: begin
        if (status_i.bit_used) begin
          state_d = S_ADV;
        end else if (status_i.idx_last) begin
          op_o    = bba_pkg::OP_IDX_RUN;
          state_d = S_MFETCH;
        end else begin
          op_o    = bba_pkg::OP_IDX_INC;
          state_d = S_FETCH;
        end
      end
      S_ADV: begin
        // skip every candidate whose run covers the used block
        if (status_i.pos_past) state_d = S_CAND;
        else if (status_i.cmd == bba_pkg::CMD_BACK) op_o = bba_pkg::OP_POS_DEC;
        else op_o = bba_pkg::OP_POS_INC;
      end
      S_MSTART: begin
        op_o    = bba_pkg::OP_IDX_RUN;
        state_d = S_MFETCH;
      end
      S_MFETCH: state_d = S_MWRITE;
      S_MWRITE: begin
        op_o    = bba_pkg::OP_MARK;
        state_d = status_i.idx_last ? S_MRES : S_MFETCH;
      end
      S_MRES: begin
        op_o    = bba_pkg::OP_RES_RUN;
        state_d = S_DONE;
      end
      S_QFETCH: state_d = S_QTEST;
      S_QTEST: begin
        op_o    = bba_pkg::OP_Q_STEP;
        state_d = status_i.q_last ? S_QRES : S_QFETCH;
      end
      S_QRES: begin
        op_o    = bba_pkg::OP_RES_QRY;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (rsp_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      req_ready_o <= 1'b0;
      rsp_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      req_ready_o <= (state_d == S_IDLE);
      rsp_valid_o <= (state_d == S_DONE);
    end
  end
endmodule

/* hdl/bitmap_block_allocator.sv */
// Top level of the bitmap block allocator: controller plus datapath.
// Depends on bba_pkg, bba_if, bba_ctrl and bba_dp.
//
// Keeps a 1024-block used/free bitmap in a 128 x 8 RAM and serves one request
// at a time: forward reserve, backward reserve, release and longest-free-run
// query. After reset the block sweeps the RAM to zero, one byte per cycle,
// before req_i.ready rises; register writes are taken at any time. Every
// bitmap access is a RAM read state followed by a test or write state. The
// candidate base is reached by stepping align_step from zero, up to
// start_block / align_step + 1 steps, and a candidate whose run covers a used
// block is skipped. The time a reserve takes grows with the blocks tested
// before a free run turns up. The response is held on rsp_o until it is
// transferred; the next request is taken in the cycle after that transfer.
module bitmap_block_allocator (
  input  logic      clk_i,
  input  logic      rst_ni,
  bba_req_if.sink   req_i,
  bba_rsp_if.source rsp_o,
  bba_cfg_if.sink   cfg_i
);
  bba_pkg::op_e        op;
  bba_pkg::dp_status_t status;

  // Register writes never stall.
  assign cfg_i.ready = 1'b1;

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .status_i    (status),
    .op_o        (op)
  );

  bba_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .req_cmd_i    (req_i.cmd),
    .req_count_i  (req_i.block_count),
    .req_start_i  (req_i.start_block),
    .req_window_i (req_i.window_len),
    .cfg_we_i     (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .status_o     (status),
    .res_ok_o     (rsp_o.success),
    .res_base_o   (rsp_o.run_base),
    .res_len_o    (rsp_o.run_length),
    .res_large_o  (rsp_o.largest_free)
  );
endmodule

/* hdl/bba_checker.sv */
// Port-level assertions for the bitmap block allocator, bound to the top.
// Depends on bba_pkg widths and on bitmap_block_allocator.
module bba_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      req_valid_i,
  input logic                      req_ready_i,
  input logic                      rsp_valid_i,
  input logic                      rsp_ready_i,
  input logic                      rsp_success_i,
  input logic [bba_pkg::IDX_W-1:0] rsp_base_i,
  input logic [bba_pkg::CNT_W-1:0] rsp_len_i,
  input logic [bba_pkg::CNT_W-1:0] rsp_large_i
);
  // One request in flight: a taken request closes the input.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("request accepted while another is in flight");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !req_ready_i)
    else $error("input open while a response is pending");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_success_i) |->
      (rsp_base_i == '0 && rsp_len_i == '0 && rsp_large_i == '0))
    else $error("failed response carries nonzero fields");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(rsp_base_i) && $stable(rsp_len_i)))
    else $error("stalled response changed");
endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_success_i (rsp_o.success),
  .rsp_base_i    (rsp_o.run_base),
  .rsp_len_i     (rsp_o.run_length),
  .rsp_large_i   (rsp_o.largest_free)
);
